### rtl/mkcs_pkg.sv
// shared types and constants for the multi-kernel 3x3 convolution sum
package mkcs_pkg;

  localparam int KSIZE     = 3;   // kernel and window side
  localparam int DATA_W    = 16;  // pixel and coefficient width
  localparam int PROD_W    = 32;  // one 16x16 signed product
  localparam int KSUM_W    = 36;  // sum of nine products
  localparam int ACC_W     = 40;  // sum over up to eight kernels
  localparam int OUT_W     = 37;  // result width
  localparam int POS_W     = 10;  // output row and column width
  localparam int CNT_W     = 13;  // width used for position compares
  localparam int KN_W      = 4;   // kernel count compares
  localparam int CFG_W     = 11;  // frame size register width
  localparam int KREG_W    = 3;   // kernel count register width
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int MIN_DIM   = 3;
  localparam int MAX_HEIGHT = 1024;

  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    CMD_COEF  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_KERNELS      = 2'd2
  } reg_idx_t;

  // position data that travels with a word down the pipeline
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } pos_t;

endpackage

### rtl/multi_kernel_conv2d_sum.sv
// multi_kernel_conv2d_sum: sum of up to NUM_KERNELS 3x3 convolutions over a padded pixel stream
// throughput: one word (pixel or coefficient write) per clock while in_stall is low
// path: a pixel passes stage 1, window, products, per-kernel sums, then the out_value register
// memory: one line memory read at the accept edge, one write back from stage 1, on separate ports
// reset (rst_n low, synchronous): counters, window, coefficients, valids cleared,
// registers back to 1024 / 1024 / 4; the line memory is covered by a fill count
module multi_kernel_conv2d_sum #(
  parameter int NUM_KERNELS = 4,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_command,
  input  logic signed [mkcs_pkg::DATA_W-1:0]     in_pixel_value,
  input  logic [1:0]                             in_coef_kernel,
  input  logic [1:0]                             in_coef_row,
  input  logic [1:0]                             in_coef_col,
  input  logic signed [mkcs_pkg::DATA_W-1:0]     in_coef_value,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mkcs_pkg::OUT_W-1:0]      out_value,
  output logic [mkcs_pkg::POS_W-1:0]             out_row,
  output logic [mkcs_pkg::POS_W-1:0]             out_col,
  output logic                                   out_last,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mkcs_pkg::PADDR_W-1:0]           paddr,
  input  logic [mkcs_pkg::PDATA_W-1:0]           pwdata,
  output logic [mkcs_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);

  localparam int CW = $clog2(MAX_WIDTH);       // column counter / memory address
  localparam int FW = $clog2(MAX_WIDTH + 1);   // fill count, can hold MAX_WIDTH
  localparam int LW = 2 * mkcs_pkg::DATA_W;    // line word: {top, mid}
  localparam int DW = mkcs_pkg::DATA_W;
  localparam int KS = mkcs_pkg::KSIZE;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [mkcs_pkg::CFG_W-1:0]  width_r;
  logic [mkcs_pkg::CFG_W-1:0]  height_r;
  logic [mkcs_pkg::KREG_W-1:0] kern_r;
  logic                        cfg_wr;
  mkcs_pkg::reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = mkcs_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mkcs_pkg::CFG_W'(1024);
      height_r <= mkcs_pkg::CFG_W'(1024);
      kern_r   <= mkcs_pkg::KREG_W'(4);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mkcs_pkg::REG_FRAME_WIDTH:  width_r  <= pwdata[mkcs_pkg::CFG_W-1:0];
        mkcs_pkg::REG_FRAME_HEIGHT: height_r <= pwdata[mkcs_pkg::CFG_W-1:0];
        mkcs_pkg::REG_KERNELS:      kern_r   <= pwdata[mkcs_pkg::KREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mkcs_pkg::REG_FRAME_WIDTH:
        prdata = mkcs_pkg::PDATA_W'(width_r);
      mkcs_pkg::REG_FRAME_HEIGHT:
        prdata = mkcs_pkg::PDATA_W'(height_r);
      mkcs_pkg::REG_KERNELS:
        prdata = mkcs_pkg::PDATA_W'(kern_r);
      default:
        prdata = '0;
    endcase
  end

  // out-of-range register values are saturated into their legal range
  logic [mkcs_pkg::CNT_W-1:0] w_eff;
  logic [mkcs_pkg::CNT_W-1:0] h_eff;
  logic [mkcs_pkg::KN_W-1:0]  nk_eff;

  always_comb begin
    priority if (mkcs_pkg::CNT_W'(width_r) < mkcs_pkg::CNT_W'(mkcs_pkg::MIN_DIM))
      w_eff = mkcs_pkg::CNT_W'(mkcs_pkg::MIN_DIM);
    else if (mkcs_pkg::CNT_W'(width_r) > mkcs_pkg::CNT_W'(MAX_WIDTH))
      w_eff = mkcs_pkg::CNT_W'(MAX_WIDTH);
    else
      w_eff = mkcs_pkg::CNT_W'(width_r);

    priority if (mkcs_pkg::CNT_W'(height_r) < mkcs_pkg::CNT_W'(mkcs_pkg::MIN_DIM))
      h_eff = mkcs_pkg::CNT_W'(mkcs_pkg::MIN_DIM);
    else if (mkcs_pkg::CNT_W'(height_r) > mkcs_pkg::CNT_W'(mkcs_pkg::MAX_HEIGHT))
      h_eff = mkcs_pkg::CNT_W'(mkcs_pkg::MAX_HEIGHT);
    else
      h_eff = mkcs_pkg::CNT_W'(height_r);

    priority if (kern_r == '0)
      nk_eff = mkcs_pkg::KN_W'(1);
    else if (mkcs_pkg::KN_W'(kern_r) > mkcs_pkg::KN_W'(NUM_KERNELS))
      nk_eff = mkcs_pkg::KN_W'(NUM_KERNELS);
    else
      nk_eff = mkcs_pkg::KN_W'(kern_r);
  end

  // ---------------------------------------------------------------------------
  // handshake: the whole pipe moves while the skid slot is free, so in_stall
  // is a register and never looks at out_stall
  // ---------------------------------------------------------------------------
  logic skid_v_r;
  logic en;
  logic accept;
  logic pix_acc;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (mkcs_pkg::cmd_t'(in_command) == mkcs_pkg::CMD_PIXEL);

  // ---------------------------------------------------------------------------
  // frame position counters (position of the next pixel)
  // ---------------------------------------------------------------------------
  logic [CW-1:0]             col_r;
  logic [mkcs_pkg::POS_W-1:0] row_r;
  logic [FW-1:0]             fill_r;   // columns 0..fill_r-1 of the line memory are written
  logic                      last_col;
  logic                      last_row;
  logic                      border;
  logic                      emit;
  logic                      line_ok;
  logic [mkcs_pkg::CNT_W-1:0] col_x;

  assign col_x    = mkcs_pkg::CNT_W'(col_r);
  assign last_col = col_x >= (w_eff - mkcs_pkg::CNT_W'(1));
  assign last_row = mkcs_pkg::CNT_W'(row_r) >= (h_eff - mkcs_pkg::CNT_W'(1));
  assign border   = (row_r == '0) || (col_r == '0) || last_col || last_row;
  assign emit     = (row_r >= mkcs_pkg::POS_W'(2)) && (col_x >= mkcs_pkg::CNT_W'(2));
  // columns are visited in order from zero, so the written set is a prefix
  assign line_ok  = FW'(col_r) < fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fill_r <= '0;
    end else if (pix_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + mkcs_pkg::POS_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
      if (FW'(col_r) == fill_r) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line memory: one word per column holding the two rows above, {top, mid}
  // read at the accept edge, written back one pipe step later
  // ---------------------------------------------------------------------------
  logic [LW-1:0] lmem [MAX_WIDTH];
  logic [LW-1:0] rd_r;
  logic          lmem_we;
  logic [LW-1:0] lmem_wd;

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      rd_r <= lmem[col_r];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: registered input word
  // ---------------------------------------------------------------------------
  logic                  s1_v_r;
  logic                  s1_pix_r;
  logic signed [DW-1:0]  s1_p_r;
  logic [CW-1:0]         s1_addr_r;
  logic                  s1_lok_r;
  logic                  s1_emit_r;
  mkcs_pkg::pos_t        s1_pos_r;
  logic [1:0]            s1_ck_r;
  logic [1:0]            s1_cr_r;
  logic [1:0]            s1_cc_r;
  logic signed [DW-1:0]  s1_cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= pix_acc;
      s1_p_r        <= border ? '0 : in_pixel_value;
      s1_addr_r     <= col_r;
      s1_lok_r      <= line_ok;
      s1_emit_r     <= emit;
      s1_pos_r.row  <= row_r - mkcs_pkg::POS_W'(2);
      s1_pos_r.col  <= mkcs_pkg::POS_W'(col_x - mkcs_pkg::CNT_W'(2));
      s1_pos_r.last <= last_col && last_row;
      s1_ck_r       <= in_coef_kernel;
      s1_cr_r       <= in_coef_row;
      s1_cc_r       <= in_coef_col;
      s1_cv_r       <= in_coef_value;
    end
  end

  // never-written line entries read as zero
  logic signed [DW-1:0] top;
  logic signed [DW-1:0] mid;
  logic                 s1_go_pix;
  logic                 s1_go_coef;

  assign top        = s1_lok_r ? rd_r[LW-1:DW] : '0;
  assign mid        = s1_lok_r ? rd_r[DW-1:0]  : '0;
  assign s1_go_pix  = en && s1_v_r && s1_pix_r;
  assign s1_go_coef = en && s1_v_r && !s1_pix_r
                      && (int'(s1_ck_r) < NUM_KERNELS)
                      && (int'(s1_cr_r) < KS) && (int'(s1_cc_r) < KS);
  assign lmem_we    = s1_go_pix;
  assign lmem_wd    = {mid, s1_p_r};

  always_ff @(posedge clk) begin
    if (lmem_we) begin
      lmem[s1_addr_r] <= lmem_wd;
    end
  end

  // window shift and coefficient store
  logic signed [DW-1:0] win_r  [KS][KS];
  logic signed [DW-1:0] coef_r [NUM_KERNELS][KS][KS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_go_pix) begin
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
      end
      win_r[0][KS-1] <= top;
      win_r[1][KS-1] <= mid;
      win_r[2][KS-1] <= s1_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_KERNELS; l++) begin
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS; j++) begin
            coef_r[l][i][j] <= '0;
          end
        end
      end
    end else if (s1_go_coef) begin
      for (int l = 0; l < NUM_KERNELS; l++) begin
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS; j++) begin
            if ((int'(s1_ck_r) == l) && (int'(s1_cr_r) == i) && (int'(s1_cc_r) == j)) begin
              coef_r[l][i][j] <= s1_cv_r;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: window is current; stage 3: products; stage 4: per-kernel sums
  // a coefficient write behind a pixel lands only after that pixel's products
  // ---------------------------------------------------------------------------
  logic           s2_v_r;
  logic           s3_v_r;
  logic           s4_v_r;
  mkcs_pkg::pos_t s2_pos_r;
  mkcs_pkg::pos_t s3_pos_r;
  mkcs_pkg::pos_t s4_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && s1_pix_r && s1_emit_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pos_r <= s1_pos_r;
      s3_pos_r <= s2_pos_r;
      s4_pos_r <= s3_pos_r;
    end
  end

  logic signed [mkcs_pkg::PROD_W-1:0] prod_r [NUM_KERNELS][KS][KS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_KERNELS; l++) begin
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS; j++) begin
            prod_r[l][i][j] <= mkcs_pkg::PROD_W'(win_r[i][j])
                               * mkcs_pkg::PROD_W'(coef_r[l][i][j]);
          end
        end
      end
    end
  end

  // kernels beyond the count in use contribute zero
  logic signed [mkcs_pkg::KSUM_W-1:0] ksum_nxt [NUM_KERNELS];
  logic signed [mkcs_pkg::KSUM_W-1:0] ksum_r   [NUM_KERNELS];

  always_comb begin
    for (int l = 0; l < NUM_KERNELS; l++) begin
      ksum_nxt[l] = '0;
      if (l < int'(nk_eff)) begin
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS; j++) begin
            ksum_nxt[l] = ksum_nxt[l] + mkcs_pkg::KSUM_W'(prod_r[l][i][j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_KERNELS; l++) begin
        ksum_r[l] <= ksum_nxt[l];
      end
    end
  end

  // total over kernels, saturated to the result width
  logic signed [mkcs_pkg::ACC_W-1:0] total;
  logic signed [mkcs_pkg::OUT_W-1:0] res_value_nxt;
  logic                              res_v;

  always_comb begin
    total = '0;
    for (int l = 0; l < NUM_KERNELS; l++) begin
      total = total + mkcs_pkg::ACC_W'(ksum_r[l]);
    end
    priority if (total > mkcs_pkg::OUT_MAX)
      res_value_nxt = mkcs_pkg::OUT_MAX[mkcs_pkg::OUT_W-1:0];
    else if (total < mkcs_pkg::OUT_MIN)
      res_value_nxt = mkcs_pkg::OUT_MIN[mkcs_pkg::OUT_W-1:0];
    else
      res_value_nxt = total[mkcs_pkg::OUT_W-1:0];
  end

  assign res_v = en && s4_v_r;

  // ---------------------------------------------------------------------------
  // output register plus one skid slot
  // ---------------------------------------------------------------------------
  logic                              out_v_r;
  logic signed [mkcs_pkg::OUT_W-1:0] out_value_r;
  mkcs_pkg::pos_t                    out_pos_r;
  logic signed [mkcs_pkg::OUT_W-1:0] skid_value_r;
  mkcs_pkg::pos_t                    skid_pos_r;
  logic                              out_take;

  assign out_take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_take) begin
      skid_v_r <= res_v;
    end else begin
      out_v_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_value_r <= skid_value_r;
        out_pos_r   <= skid_pos_r;
      end
    end else if (out_v_r && !out_take) begin
      skid_value_r <= res_value_nxt;
      skid_pos_r   <= s4_pos_r;
    end else begin
      out_value_r <= res_value_nxt;
      out_pos_r   <= s4_pos_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_value = out_value_r;
  assign out_row   = out_pos_r.row;
  assign out_col   = out_pos_r.col;
  assign out_last  = out_pos_r.last;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full with empty output register");

  a_col_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(col_r) <= fill_r)
    else $error("column counter ahead of line memory fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_WIDTH))
    else $error("line memory fill count beyond depth");

  a_result_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v && out_v_r && out_stall) |=> skid_v_r)
    else $error("result lost while output stalled");

  a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && s1_v_r) |=> (s1_v_r && $stable(s1_p_r) && $stable(s1_addr_r)))
    else $error("stage 1 moved while pipe frozen");

endmodule
